@@ rtl/core/fre_pkg.sv @@
// Shared types, constants and constant functions of the functional response evaluator.
`default_nettype none
package fre_pkg;

  localparam int TAYLOR_ORDER = 13;
  localparam int EXP_STEPS    = 32;
  localparam int PROP_BITS    = 16;

  localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
  localparam logic [32:0] HALF_LSB32  = 33'h0_8000_0000;
  localparam logic [37:0] EXP_CAP_Q32 = 38'h20_0000_0000;
  localparam logic [16:0] PROP_ONE    = 17'h1_0000;
  localparam logic [32:0] PROP_ROUND  = 33'h0_0000_8000;

  typedef enum logic {
    CFG_ATTACK_RATE = 1'b0,
    CFG_TIME_STEP   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] prey;
    logic [31:0] demand;
  } dens_t;

  typedef struct packed {
    dens_t       dens;
    logic [32:0] eff;
  } effs_t;

  typedef struct packed {
    dens_t       dens;
    logic [32:0] eff;
    logic        ovf;
  } divy_tag_t;

  typedef struct packed {
    logic [31:0] raw;
    dens_t       dens;
    logic [32:0] eff;
    logic        ovf;
  } divr_tag_t;

  // ceil(2^36 / n), exact floor division by n for 32-bit dividends
  function automatic logic [36:0] recip36(input int n);
    case (n)
      1:       return 37'd68719476736;
      2:       return 37'd34359738368;
      3:       return 37'd22906492246;
      4:       return 37'd17179869184;
      5:       return 37'd13743895348;
      6:       return 37'd11453246123;
      7:       return 37'd9817068106;
      8:       return 37'd8589934592;
      9:       return 37'd7635497416;
      10:      return 37'd6871947674;
      11:      return 37'd6247225158;
      12:      return 37'd5726623062;
      13:      return 37'd5286113596;
      default: return 37'd0;
    endcase
  endfunction

  function automatic logic [32:0] exp_frac_c(input logic [31:0] f);
    logic [32:0] t;
    logic [79:0] pr;
    t = ONE_Q32;
    for (int n = TAYLOR_ORDER; n >= 1; n--) begin
      pr = (80'(f) * 80'(t)) >> 32;
      pr = (pr * 80'(recip36(n))) >> 36;
      t  = ONE_Q32 - pr[32:0];
    end
    return t;
  endfunction

  localparam logic [32:0] HALF_EXP = exp_frac_c(32'h8000_0000);
  localparam logic [31:0] E1_Q32   = 32'((66'(HALF_EXP) * 66'(HALF_EXP)) >> 32);

endpackage
`default_nettype wire

@@ rtl/core/fre_exp.sv @@
// Pipelined exp(-v) unit: Horner Taylor series for the fraction, then integer powers.
`default_nettype none
module fre_exp import fre_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [37:0]      in_v,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [32:0]      out_r,
  output logic [TAG_W-1:0] out_tag
);

  localparam int HS = 2 * TAYLOR_ORDER;
  localparam int NS = HS + EXP_STEPS;

  logic             vld_r [NS];
  logic [32:0]      val_r [NS];
  logic [TAG_W-1:0] tag_r [NS];
  logic [5:0]       k_r   [NS-1];
  logic [31:0]      f_r   [HS-1];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic             src_vld;
    logic [32:0]      src_val;
    logic [5:0]       src_k;
    logic [TAG_W-1:0] src_tag;
    logic [32:0]      val_nxt;

    if (s == 0) begin : g_src_in
      assign src_vld = in_vld;
      assign src_val = ONE_Q32;
      assign src_k   = in_v[37:32];
      assign src_tag = in_tag;
    end else begin : g_src_prev
      assign src_vld = vld_r[s-1];
      assign src_val = val_r[s-1];
      assign src_k   = k_r[s-1];
      assign src_tag = tag_r[s-1];
    end

    if (s < HS) begin : g_horner
      logic [31:0] src_f;
      if (s == 0) begin : g_f_in
        assign src_f = in_v[31:0];
      end else begin : g_f_prev
        assign src_f = f_r[s-1];
      end
      if (s % 2 == 0) begin : g_mul
        logic [64:0] mp;
        assign mp      = 65'(src_f) * 65'(src_val);
        assign val_nxt = {1'b0, mp[63:32]};
      end else begin : g_div
        localparam logic [36:0] RC = recip36(TAYLOR_ORDER - s / 2);
        logic [68:0] qp;
        assign qp      = 69'(src_val[31:0]) * 69'(RC);
        assign val_nxt = ONE_Q32 - {1'b0, qp[67:36]};
      end
      if (s < HS - 1) begin : g_f_reg
        always_ff @(posedge clk) begin
          if (en) f_r[s] <= src_f;
        end
      end
    end else begin : g_pow
      localparam int J = s - HS;
      logic [64:0] mp;
      assign mp      = 65'(src_val) * 65'(E1_Q32);
      assign val_nxt = (src_k > 6'(J)) ? mp[64:32] : src_val;
    end

    if (s < NS - 1) begin : g_k_reg
      always_ff @(posedge clk) begin
        if (en) k_r[s] <= src_k;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[s] <= val_nxt;
        tag_r[s] <= src_tag;
      end
    end
  end

  assign out_vld = vld_r[NS-1];
  assign out_r   = val_r[NS-1];
  assign out_tag = tag_r[NS-1];

endmodule
`default_nettype wire

@@ rtl/core/fre_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module fre_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32,
  parameter int Q_W   = 17,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [Q_W-1:0]   out_q,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [TAG_W-1:0] tag_r [Q_W];
  logic [DEN_W-1:0] rem_r [Q_W-1];
  logic [Q_W-1:0]   lo_r  [Q_W-1];
  logic [DEN_W-1:0] den_r [Q_W-1];

  for (genvar s = 0; s < Q_W; s++) begin : g_st
    logic             src_vld;
    logic [DEN_W-1:0] src_rem;
    logic [Q_W-1:0]   src_lo;
    logic [DEN_W-1:0] src_den;
    logic [Q_W-1:0]   src_q;
    logic [TAG_W-1:0] src_tag;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_src_in
      assign src_vld = in_vld;
      assign src_rem = DEN_W'(in_num >> Q_W);
      assign src_lo  = in_num[Q_W-1:0];
      assign src_den = in_den;
      assign src_q   = '0;
      assign src_tag = in_tag;
    end else begin : g_src_prev
      assign src_vld = vld_r[s-1];
      assign src_rem = rem_r[s-1];
      assign src_lo  = lo_r[s-1];
      assign src_den = den_r[s-1];
      assign src_q   = q_r[s-1];
      assign src_tag = tag_r[s-1];
    end

    assign trial = {src_rem, src_lo[Q_W-1-s]};
    assign ge    = trial >= {1'b0, src_den};
    assign diff  = trial - {1'b0, src_den};

    if (s < Q_W - 1) begin : g_rem_reg
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          lo_r[s]  <= src_lo;
          den_r[s] <= src_den;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]   <= {src_q[Q_W-2:0], ge};
        tag_r[s] <= src_tag;
      end
    end
  end

  assign out_vld = vld_r[Q_W-1];
  assign out_q   = q_r[Q_W-1];
  assign out_tag = tag_r[Q_W-1];

endmodule
`default_nettype wire

@@ rtl/core/functional_response_eval.sv @@
// Top level of the functional response evaluator.
// Pipeline from request to result: two multiplier stages, two 58-stage exp units,
// a multiplier stage before the 39-stage divider, another after the second exp unit,
// two parallel 17-stage dividers and the output register. Throughput: one
// request per cycle; the whole pipeline advances whenever the output register is empty or taken.
// Reset: synchronous active-low; clears valid bits, attack_rate to 0, time_step to 1.0.
`default_nettype none
module functional_response_eval import fre_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_attacker_density,
  input  logic [31:0] in_prey_density,
  input  logic [31:0] in_gross_demand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_gross_supply,
  output logic [16:0] out_prey_attacked_fraction,
  output logic [16:0] out_search_efficacy,
  output logic [16:0] out_supply_demand_ratio
);

  localparam logic [63:0] CAP_F = 64'(32) << FRAC_BITS;
  localparam int YQ_W = 39;
  localparam int RQ_W = PROP_BITS + 1;

  logic [31:0] attack_rate_r;
  logic [31:0] time_step_r;
  logic        out_valid_r;
  logic        ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_rate_r <= '0;
      time_step_r   <= 32'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ATTACK_RATE: attack_rate_r <= cfg_wdata;
        CFG_TIME_STEP:   time_step_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ce       = !out_valid_r || out_ready;
  assign in_ready = ce;

  // stage 1: a*N
  logic        v1_r;
  logic [63:0] m1_r;
  dens_t       dn1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m1_r  <= 64'(attack_rate_r) * 64'(in_attacker_density);
      dn1_r <= '{prey: in_prey_density, demand: in_gross_demand};
    end
  end

  // stage 2: saturate, times dt
  logic        v2_r;
  logic [63:0] m2_r;
  dens_t       dn2_r;
  logic [63:0] p_sh;
  logic [31:0] p_sat;

  assign p_sh  = m1_r >> FRAC_BITS;
  assign p_sat = (p_sh > 64'h0000_0000_FFFF_FFFF) ? '1 : p_sh[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ce) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m2_r  <= 64'(p_sat) * 64'(time_step_r);
      dn2_r <= dn1_r;
    end
  end

  // exponent for efficacy
  logic [63:0] x_sh;
  logic [63:0] x_cap;
  logic [37:0] va;
  logic        ea_vld;
  logic [32:0] ea_r;
  dens_t       ea_tag;

  assign x_sh  = m2_r >> FRAC_BITS;
  assign x_cap = (x_sh > CAP_F) ? CAP_F : x_sh;
  assign va    = 38'(x_cap << (32 - FRAC_BITS));

  fre_exp #(.TAG_W($bits(dens_t))) u_exp_eff (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (ce),
    .in_vld  (v2_r),
    .in_v    (va),
    .in_tag  (dn2_r),
    .out_vld (ea_vld),
    .out_r   (ea_r),
    .out_tag (ea_tag)
  );

  // stage 4: E*P
  logic        v4_r;
  logic [64:0] m4_r;
  dens_t       dn4_r;
  logic [32:0] eff4_r;
  logic [32:0] eff_a;

  assign eff_a = ONE_Q32 - ea_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (ce) begin
      v4_r <= ea_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m4_r   <= 65'(eff_a) * 65'(ea_tag.prey);
      dn4_r  <= ea_tag;
      eff4_r <= eff_a;
    end
  end

  // y = E*P/D
  divy_tag_t      dy_in_tag;
  logic           dy_vld;
  logic [YQ_W-1:0] dy_q;
  divy_tag_t      dy_tag;

  assign dy_in_tag = '{dens: dn4_r, eff: eff4_r,
                       ovf: (65'(m4_r >> YQ_W) >= 65'(dn4_r.demand))};

  fre_div #(.NUM_W(65), .DEN_W(32), .Q_W(YQ_W), .TAG_W($bits(divy_tag_t))) u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (ce),
    .in_vld  (v4_r),
    .in_num  (m4_r),
    .in_den  (dn4_r.demand),
    .in_tag  (dy_in_tag),
    .out_vld (dy_vld),
    .out_q   (dy_q),
    .out_tag (dy_tag)
  );

  logic [37:0] vy;
  effs_t       eb_in_tag;
  logic        eb_vld;
  logic [32:0] eb_r;
  effs_t       eb_tag;

  assign vy = (dy_tag.ovf || (dy_q > YQ_W'(EXP_CAP_Q32))) ? EXP_CAP_Q32 : dy_q[37:0];
  assign eb_in_tag = '{dens: dy_tag.dens, eff: dy_tag.eff};

  fre_exp #(.TAG_W($bits(effs_t))) u_exp_sup (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (ce),
    .in_vld  (dy_vld),
    .in_v    (vy),
    .in_tag  (eb_in_tag),
    .out_vld (eb_vld),
    .out_r   (eb_r),
    .out_tag (eb_tag)
  );

  // stage 7: D*(1-exp(-y)), rounded
  logic        v7_r;
  logic [64:0] m7_r;
  dens_t       dn7_r;
  logic [32:0] eff7_r;
  logic [31:0] raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (ce) begin
      v7_r <= eb_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m7_r   <= 65'(eb_tag.dens.demand) * 65'(ONE_Q32 - eb_r) + 65'(HALF_LSB32);
      dn7_r  <= eb_tag.dens;
      eff7_r <= eb_tag.eff;
    end
  end

  assign raw = m7_r[63:32];

  // ratios S/D and S/P
  logic [47:0]     rnum;
  divr_tag_t       dr_in_tag;
  logic            ovf_f;
  logic            dr_vld;
  logic [RQ_W-1:0] dr_q;
  divr_tag_t       dr_tag;
  logic            df_vld;
  logic [RQ_W-1:0] df_q;
  logic            df_ovf;

  assign rnum      = 48'(raw) << PROP_BITS;
  assign ovf_f     = (rnum >> RQ_W) >= 48'(dn7_r.prey);
  assign dr_in_tag = '{raw: raw, dens: dn7_r, eff: eff7_r,
                       ovf: ((rnum >> RQ_W) >= 48'(dn7_r.demand))};

  fre_div #(.NUM_W(48), .DEN_W(32), .Q_W(RQ_W), .TAG_W($bits(divr_tag_t))) u_div_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (ce),
    .in_vld  (v7_r),
    .in_num  (rnum),
    .in_den  (dn7_r.demand),
    .in_tag  (dr_in_tag),
    .out_vld (dr_vld),
    .out_q   (dr_q),
    .out_tag (dr_tag)
  );

  fre_div #(.NUM_W(48), .DEN_W(32), .Q_W(RQ_W), .TAG_W(1)) u_div_frac (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (ce),
    .in_vld  (v7_r),
    .in_num  (rnum),
    .in_den  (dn7_r.prey),
    .in_tag  (ovf_f),
    .out_vld (df_vld),
    .out_q   (df_q),
    .out_tag (df_ovf)
  );

  // output register
  logic [31:0] sup_nxt;
  logic [16:0] frac_nxt;
  logic [16:0] ratio_nxt;
  logic [16:0] eff_nxt;
  logic [32:0] eff_rnd;

  always_comb begin
    sup_nxt = dr_tag.raw;
    if (sup_nxt > dr_tag.dens.demand) sup_nxt = dr_tag.dens.demand;
    if (sup_nxt > dr_tag.dens.prey) sup_nxt = dr_tag.dens.prey;

    if (dr_tag.dens.prey == '0) begin
      frac_nxt = '0;
    end else if (df_ovf || (df_q > PROP_ONE)) begin
      frac_nxt = PROP_ONE;
    end else begin
      frac_nxt = df_q;
    end

    if (dr_tag.dens.demand == '0) begin
      ratio_nxt = '0;
    end else if (dr_tag.ovf || (dr_q > PROP_ONE)) begin
      ratio_nxt = PROP_ONE;
    end else begin
      ratio_nxt = dr_q;
    end

    eff_rnd = dr_tag.eff + PROP_ROUND;
    eff_nxt = eff_rnd[32:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= dr_vld && df_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_gross_supply           <= sup_nxt;
      out_prey_attacked_fraction <= frac_nxt;
      out_search_efficacy        <= eff_nxt;
      out_supply_demand_ratio    <= ratio_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/core/fre_chk.sv @@
// Port-level checker for the functional response evaluator, bound to the top level.
`default_nettype none
module fre_chk import fre_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_gross_supply,
  input wire logic [16:0] out_prey_attacked_fraction,
  input wire logic [16:0] out_search_efficacy,
  input wire logic [16:0] out_supply_demand_ratio
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("request refused while output can advance");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_gross_supply)))
    else $error("stalled result dropped or changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_search_efficacy <= PROP_ONE) &&
                   (out_prey_attacked_fraction <= PROP_ONE) &&
                   (out_supply_demand_ratio <= PROP_ONE)))
    else $error("proportion above one");

endmodule

bind functional_response_eval fre_chk u_fre_chk (.*);
`default_nettype wire

@@ test/functional_response_eval_tb.sv @@
// Self-checking testbench for the functional response evaluator, with its own response predictor.
`timescale 1ns / 1ps
module functional_response_eval_tb;
  import fre_pkg::*;

  typedef struct {
    logic [31:0] attacker;
    logic [31:0] prey;
    logic [31:0] demand;
  } request_t;

  typedef struct {
    logic [31:0] supply;
    logic [16:0] fraction;
    logic [16:0] efficacy;
    logic [16:0] ratio;
  } response_t;

  localparam int FRAC = 16;
  localparam logic [63:0] ONE = 64'h1_0000_0000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_attacker_density;
  logic [31:0] in_prey_density;
  logic [31:0] in_gross_demand;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_gross_supply;
  logic [16:0] out_prey_attacked_fraction;
  logic [16:0] out_search_efficacy;
  logic [16:0] out_supply_demand_ratio;

  logic [31:0] model_attack_rate;
  logic [31:0] model_time_step;
  request_t    pending_reqs[$];
  response_t   expected_resps[$];
  int          err_count;
  int          send_gap;
  int          recv_stall;
  bit          no_idle;

  functional_response_eval u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_attacker_density(in_attacker_density),
    .in_prey_density(in_prey_density),
    .in_gross_demand(in_gross_demand),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_gross_supply(out_gross_supply),
    .out_prey_attacked_fraction(out_prey_attacked_fraction),
    .out_search_efficacy(out_search_efficacy),
    .out_supply_demand_ratio(out_supply_demand_ratio)
  );

  function automatic logic [63:0] taylor_exp_frac(logic [63:0] f);
    logic [63:0] t;
    t = ONE;
    for (int n = TAYLOR_ORDER; n >= 1; n--) begin
      t = ONE - (((f * t) >> 32) / n);
    end
    return t;
  endfunction

  function automatic logic [63:0] decay(logic [63:0] v);
    logic [63:0] k;
    logic [63:0] r;
    logic [63:0] h;
    logic [63:0] e1;
    k = v >> 32;
    r = taylor_exp_frac(v & 64'hFFFF_FFFF);
    h = taylor_exp_frac(64'h8000_0000);
    e1 = (h * h) >> 32;
    if (k > 32) k = 32;
    for (int i = 0; i < k; i++) r = (r * e1) >> 32;
    return r;
  endfunction

  function automatic response_t predict_response(request_t rq);
    response_t   rs;
    logic [63:0] p;
    logic [63:0] x;
    logic [63:0] eff;
    logic [63:0] y;
    logic [63:0] raw;
    logic [63:0] frac;
    logic [63:0] ratio;
    logic [63:0] supply;
    raw = 0;
    frac = 0;
    ratio = 0;
    p = (64'(model_attack_rate) * 64'(rq.attacker)) >> FRAC;
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    x = (p * 64'(model_time_step)) >> FRAC;
    if (x > (64'd32 << FRAC)) x = 64'd32 << FRAC;
    eff = ONE - decay(x << (32 - FRAC));
    if (rq.demand != 0) begin
      y = (eff * 64'(rq.prey)) / 64'(rq.demand);
      if (y > (64'd32 << 32)) y = 64'd32 << 32;
      raw = (64'(rq.demand) * (ONE - decay(y)) + 64'h8000_0000) >> 32;
      ratio = (raw << 16) / 64'(rq.demand);
      if (ratio > 65536) ratio = 65536;
    end
    if (rq.prey != 0) begin
      frac = (raw << 16) / 64'(rq.prey);
      if (frac > 65536) frac = 65536;
    end
    supply = raw;
    if (supply > rq.demand) supply = rq.demand;
    if (supply > rq.prey) supply = rq.prey;
    rs.supply = supply[31:0];
    rs.fraction = frac[16:0];
    rs.efficacy = 17'((eff + 64'h8000) >> 16);
    rs.ratio = ratio[16:0];
    return rs;
  endfunction

  function automatic logic [31:0] rand_density();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 4) << 16;
      default: return ($urandom >> $urandom_range(8, 24)) + 32'h100;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    bit take;
    request_t rq;
    take = !in_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_resps.push_back(predict_response('{in_attacker_density, in_prey_density,
                                                    in_gross_demand}));
        send_gap = no_idle ? 0 : $urandom_range(0, 10);
        take = 1'b1;
      end
      if (take) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          rq = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_attacker_density <= rq.attacker;
          in_prey_density <= rq.prey;
          in_gross_demand <= rq.demand;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    response_t ex;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          $error("unexpected response supply=%0h", out_gross_supply);
          err_count++;
        end else begin
          ex = expected_resps.pop_front();
          if (out_gross_supply !== ex.supply) begin
            $error("gross_supply exp %0h got %0h", ex.supply, out_gross_supply);
            err_count++;
          end
          if (out_prey_attacked_fraction !== ex.fraction) begin
            $error("prey_attacked_fraction exp %0h got %0h", ex.fraction,
                   out_prey_attacked_fraction);
            err_count++;
          end
          if (out_search_efficacy !== ex.efficacy) begin
            $error("search_efficacy exp %0h got %0h", ex.efficacy, out_search_efficacy);
            err_count++;
          end
          if (out_supply_demand_ratio !== ex.ratio) begin
            $error("supply_demand_ratio exp %0h got %0h", ex.ratio, out_supply_demand_ratio);
            err_count++;
          end
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ATTACK_RATE) model_attack_rate = val;
    else model_time_step = val;
  endtask

  initial begin
    logic [31:0] ar_set[8];
    logic [31:0] ts_set[8];
    err_count = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_attacker_density = '0;
    in_prey_density = '0;
    in_gross_demand = '0;
    model_attack_rate = 32'h0;
    model_time_step = 32'h1_0000;
    ar_set = '{32'h0, 32'h1_0000, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0};
    ts_set = '{32'h1_0000, 32'h1_0000, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0,
               32'h0};
    for (int i = 5; i < 8; i++) begin
      ar_set[i] = $urandom >> $urandom_range(8, 20);
      ts_set[i] = $urandom >> $urandom_range(8, 20);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    pending_reqs.push_back('{32'h1_0000, 32'h1_0000, 32'h1_0000});
    pending_reqs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(CFG_ATTACK_RATE, ar_set[ph]);
        write_reg(CFG_TIME_STEP, ts_set[ph]);
      end
      no_idle = (ph == 3);
      if (ph == 1 || ph == 2) begin
        pending_reqs.push_back('{32'h0, 32'h0, 32'h0});
        pending_reqs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_reqs.push_back('{32'h1_0000, 32'h0, 32'h1_0000});
        pending_reqs.push_back('{32'h1_0000, 32'h1_0000, 32'h0});
        pending_reqs.push_back('{32'hFFFF_FFFF, 32'h0, 32'h0});
        pending_reqs.push_back('{32'h1_0000, 32'hFFFF_FFFF, 32'h1});
        pending_reqs.push_back('{32'h1_0000, 32'h1, 32'hFFFF_FFFF});
        pending_reqs.push_back('{32'h2_0000, 32'h5_0000, 32'h3_0000});
        pending_reqs.push_back('{32'h8000, 32'h1_0000, 32'h4_0000});
        pending_reqs.push_back('{32'h20_0000, 32'h1_0000, 32'h1_0000});
        pending_reqs.push_back('{32'h1, 32'h1, 32'h1});
      end
      for (int i = 0; i < 138; i++)
        pending_reqs.push_back('{rand_density(), rand_density(), rand_density()});
    end
    drain();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
